FILE: src/sledc_pkg.sv
// Shared types and constants for the status LED blink and fade controller.
// Holds the item structs, operation and register codes, and the
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package sledc_pkg;

   // Operation codes of an input item.
   localparam logic [2:0] OP_SET_STATIC = 3'd0;
   localparam logic [2:0] OP_STATIC_ON  = 3'd1;
   localparam logic [2:0] OP_STATIC_OFF = 3'd2;
   localparam logic [2:0] OP_BLINK_ONCE = 3'd3;
   localparam logic [2:0] OP_QUERY      = 3'd4;
   localparam logic [2:0] OP_TICK       = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [1:0] CSR_BLINK_LEN  = 2'd1;
   localparam logic [1:0] CSR_REFRESH    = 2'd2;

   // Register reset values.
   localparam logic [7:0]  BRIGHTNESS_RESET = 8'd255;
   localparam logic [15:0] BLINK_LEN_RESET  = 16'd200;
   localparam logic [15:0] REFRESH_RESET    = 16'd10;

   // Brightness codes with special meaning.
   localparam logic [7:0] LEVEL_FULL = 8'd255;
   localparam logic [7:0] LEVEL_OFF  = 8'd0;

   // Result kinds.
   localparam logic RESULT_PIXEL = 1'b0;
   localparam logic RESULT_QUERY = 1'b1;

   typedef struct packed {
      logic [2:0] operation;
      logic [2:0] led_index;
      logic       red_sel;
      logic       green_sel;
      logic       blue_sel;
      logic       usb_activity;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [2:0]  result_led;
      logic [23:0] pixel_color;
      logic        last_pixel;
      logic        static_red;
      logic        static_green;
      logic        static_blue;
      logic        blinking_red;
      logic        blinking_green;
      logic        blinking_blue;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;           // capture the accepted item
      logic exec;           // execute a command or answer a query
      logic tick;           // advance the millisecond clock
      logic start_refresh;  // record refresh time and aim the LED pointer
      logic arm_usb;        // arm the blue blink on the USB LED
      logic timer_step;     // retire due timers of the current LED
      logic pixel_step;     // emit the pixel word of the current LED
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic is_query;
      logic refresh_due;
      logic usb_pending;
      logic last_led;
      logic out_free;
   } status_type;

endpackage

FILE: src/status_led_blink_fade_controller.sv
// Status LED blink and fade controller for NUM_LEDS RGB status LEDs. Commands
// set, OR in or clear static colours, arm a single blink per colour, or query
// one LED; a tick item advances the millisecond clock, and once per refresh
// period it retires due timers, arms a blue blink on the USB LED after USB
// activity, scales by brightness with fade, and emits one GRB item per LED.
// Queries and pixel items wait while the result side stalls; the controller
// walks the LEDs one at a time through a single LED pointer. Results wait
// in an output register, so the next item is taken while the last result
// is still pending.
`timescale 1ns / 1ps

module status_led_blink_fade_controller #(
   parameter int NUM_LEDS      = 8,
   parameter int USB_LED_INDEX = 5,
   parameter int TIME_BITS     = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sledc_pkg::req_type  req_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sledc_pkg::rsp_type  rsp_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

   sledc_pkg::cmd_type    cmd;
   sledc_pkg::status_type status;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   sledc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sledc_datapath #(
      .NUM_LEDS      (NUM_LEDS),
      .USB_LED_INDEX (USB_LED_INDEX),
      .TIME_BITS     (TIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: src/sledc_ctrl.sv
// Controller state machine of the status LED blink and fade controller.
// Sequences command execution and the per-LED refresh walk.
// Depends on sledc_pkg for the command and status structs.
`timescale 1ns / 1ps

module sledc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sledc_pkg::status_type  status,
   output sledc_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_USB    = 3'd3;
   localparam logic [2:0] ST_TIMER  = 3'd4;
   localparam logic [2:0] ST_PIXEL  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_tick) begin
               cmd.tick = 1'b1;
               state_in = ST_CHECK;
            end else if (status.is_query) begin
               // A query answer waits for the output register to free up.
               if (status.out_free) begin
                  cmd.exec = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (status.refresh_due) begin
               cmd.start_refresh = 1'b1;
               state_in = status.usb_pending ? ST_USB : ST_TIMER;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_USB: begin
            cmd.arm_usb = 1'b1;
            state_in    = ST_TIMER;
         end
         ST_TIMER: begin
            cmd.timer_step = 1'b1;
            state_in       = ST_PIXEL;
         end
         ST_PIXEL: begin
            if (status.out_free) begin
               cmd.pixel_step = 1'b1;
               state_in       = status.last_led ? ST_IDLE : ST_TIMER;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/sledc_datapath.sv
// Datapath of the status LED blink and fade controller: LED state, timers,
// configuration registers, brightness and fade, and the output register.
// Depends on sledc_pkg; driven by sledc_ctrl through cmd_type.
`timescale 1ns / 1ps

module sledc_datapath #(
   parameter int NUM_LEDS      = 8,
   parameter int USB_LED_INDEX = 5,
   parameter int TIME_BITS     = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sledc_pkg::req_type     req_item,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   output sledc_pkg::rsp_type     rsp_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sledc_pkg::cmd_type     cmd,
   output sledc_pkg::status_type  status
);

   localparam int PTR_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam logic [PTR_W-1:0] USB_PTR = PTR_W'(USB_LED_INDEX % NUM_LEDS);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(NUM_LEDS - 1);

   typedef logic [TIME_BITS-1:0] time_type;

   // Halve-down / double-up fade toward the wanted level.
   function automatic logic [7:0] fade(input logic [7:0] want, input logic [7:0] prev);
      logic [7:0] v;
      logic [8:0] prev2;
      begin
         v     = want;
         prev2 = {prev, 1'b0};
         if (v < prev) begin
            v = prev >> 1;
         end
         if (v != 8'd0 && prev == 8'd0) begin
            v = 8'd1;
         end else if (v > prev && {1'b0, v} > prev2) begin
            v = prev2[7:0];
         end
         return v;
      end
   endfunction

   // Item and pointer.
   sledc_pkg::req_type item_ff, item_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;

   // LED state.
   logic [2:0] static_ff [NUM_LEDS];
   logic [2:0] static_in [NUM_LEDS];
   logic [2:0] blink_ff  [NUM_LEDS];
   logic [2:0] blink_in  [NUM_LEDS];
   time_type   on_ff     [NUM_LEDS][3];
   time_type   on_in     [NUM_LEDS][3];
   time_type   off_ff    [NUM_LEDS][3];
   time_type   off_in    [NUM_LEDS][3];
   logic [7:0] prev_ff   [NUM_LEDS][3];
   logic [7:0] prev_in   [NUM_LEDS][3];

   // Clock, refresh time and USB latch.
   time_type clock_ff, clock_in;
   time_type last_ff, last_in;
   logic     usb_ff, usb_in;

   // Configuration.
   logic [7:0]  bright_ff, bright_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] period_ff, period_in;

   // Output register.
   sledc_pkg::rsp_type out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   // Working signals.
   logic       ok;
   logic       out_free;
   logic [2:0] sel;
   logic [2:0] arm_sel;
   time_type   now_plus_len;
   time_type   refresh_at;
   time_type   cur_on  [3];
   time_type   cur_off [3];
   time_type   arm_on  [3];
   logic [2:0] off_due;
   logic [2:0] on_due;
   logic [2:0] timer_bits;
   logic [2:0] pix_bits;
   logic [7:0] want [3];
   logic [7:0] lv   [3];

   assign ok           = (int'(item_ff.led_index) < NUM_LEDS);
   assign out_free     = !out_valid_ff || rsp_ready;
   assign sel          = {item_ff.blue_sel, item_ff.green_sel, item_ff.red_sel};
   assign arm_sel      = cmd.arm_usb ? 3'b100 : sel;
   assign now_plus_len = TIME_BITS'(clock_ff + TIME_BITS'(len_ff));
   assign refresh_at   = TIME_BITS'(last_ff + TIME_BITS'(period_ff));

   assign status.is_tick     = (item_ff.operation == sledc_pkg::OP_TICK);
   assign status.is_query    = (item_ff.operation == sledc_pkg::OP_QUERY);
   assign status.refresh_due = !(refresh_at > clock_ff);
   assign status.usb_pending = usb_ff;
   assign status.last_led    = (ptr_ff == LAST_PTR);
   assign status.out_free    = out_free;

   assign rsp_item  = out_ff;
   assign rsp_valid = out_valid_ff;

   // Per-colour timer views of the LED under the pointer.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cur_on[c]  = on_ff[ptr_ff][c];
         cur_off[c] = off_ff[ptr_ff][c];
         // Arming a blink queues it behind a running one, else starts now.
         if (cur_off[c] != '0) begin
            arm_on[c] = TIME_BITS'(cur_off[c] + TIME_BITS'(len_ff));
         end else begin
            arm_on[c] = clock_ff;
         end
         off_due[c] = (cur_off[c] != '0) && (cur_off[c] < clock_ff);
         on_due[c]  = (cur_on[c] != '0) && (cur_on[c] < clock_ff);
      end
      timer_bits = (blink_ff[ptr_ff] & ~off_due) | on_due;
   end

   // Brightness scaling and fade for the LED under the pointer.
   always_comb begin
      pix_bits = static_ff[ptr_ff] | blink_ff[ptr_ff];
      for (int c = 0; c < 3; c++) begin
         want[c] = pix_bits[c] ? bright_ff : 8'd0;
         if (bright_ff == sledc_pkg::LEVEL_OFF) begin
            lv[c] = 8'd0;
         end else if (bright_ff == sledc_pkg::LEVEL_FULL) begin
            lv[c] = pix_bits[c] ? 8'd255 : 8'd0;
         end else begin
            lv[c] = fade(want[c], prev_ff[ptr_ff][c]);
         end
      end
   end

   // Next-state logic for all registers.
   always_comb begin
      item_in      = item_ff;
      ptr_in       = ptr_ff;
      static_in    = static_ff;
      blink_in     = blink_ff;
      on_in        = on_ff;
      off_in       = off_ff;
      prev_in      = prev_ff;
      clock_in     = clock_ff;
      last_in      = last_ff;
      usb_in       = usb_ff;
      bright_in    = bright_ff;
      len_in       = len_ff;
      period_in    = period_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      // Configuration writes.
      if (csr_valid) begin
         case (csr_index)
            sledc_pkg::CSR_BRIGHTNESS: bright_in = csr_data[7:0];
            sledc_pkg::CSR_BLINK_LEN:  len_in    = csr_data;
            sledc_pkg::CSR_REFRESH:    period_in = csr_data;
            default: begin
            end
         endcase
      end

      // Capture an accepted item; USB activity is latched on every item.
      if (cmd.load) begin
         item_in = req_item;
         ptr_in  = PTR_W'(req_item.led_index);
         usb_in  = usb_ff | req_item.usb_activity;
      end

      // Commands and queries.
      if (cmd.exec) begin
         case (item_ff.operation)
            sledc_pkg::OP_SET_STATIC: begin
               if (ok) static_in[ptr_ff] = sel;
            end
            sledc_pkg::OP_STATIC_ON: begin
               if (ok) static_in[ptr_ff] = static_ff[ptr_ff] | sel;
            end
            sledc_pkg::OP_STATIC_OFF: begin
               if (ok) static_in[ptr_ff] = static_ff[ptr_ff] & ~sel;
            end
            sledc_pkg::OP_BLINK_ONCE: begin
               if (ok) begin
                  for (int c = 0; c < 3; c++) begin
                     if (arm_sel[c] && cur_on[c] == '0) on_in[ptr_ff][c] = arm_on[c];
                  end
               end
            end
            sledc_pkg::OP_QUERY: begin
               out_in             = '0;
               out_in.result_kind = sledc_pkg::RESULT_QUERY;
               out_in.result_led  = item_ff.led_index;
               if (ok) begin
                  out_in.static_red     = static_ff[ptr_ff][0];
                  out_in.static_green   = static_ff[ptr_ff][1];
                  out_in.static_blue    = static_ff[ptr_ff][2];
                  out_in.blinking_red   = (cur_on[0] != '0) || (cur_off[0] != '0);
                  out_in.blinking_green = (cur_on[1] != '0) || (cur_off[1] != '0);
                  out_in.blinking_blue  = (cur_on[2] != '0) || (cur_off[2] != '0);
               end
               out_valid_in = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Millisecond tick.
      if (cmd.tick) begin
         clock_in = TIME_BITS'(clock_ff + TIME_BITS'(1));
      end

      // Start of a refresh run: aim at the USB LED if a blink must be armed.
      if (cmd.start_refresh) begin
         last_in = clock_ff;
         ptr_in  = usb_ff ? USB_PTR : '0;
      end

      // USB activity arms a blue blink on the USB LED.
      if (cmd.arm_usb) begin
         usb_in = 1'b0;
         ptr_in = '0;
         for (int c = 0; c < 3; c++) begin
            if (arm_sel[c] && cur_on[c] == '0) on_in[ptr_ff][c] = arm_on[c];
         end
      end

      // Retire due off timers, then due on timers, of the current LED.
      if (cmd.timer_step) begin
         blink_in[ptr_ff] = timer_bits;
         for (int c = 0; c < 3; c++) begin
            if (on_due[c]) begin
               on_in[ptr_ff][c]  = '0;
               off_in[ptr_ff][c] = now_plus_len;
            end else if (off_due[c]) begin
               off_in[ptr_ff][c] = '0;
            end
         end
      end

      // Emit the pixel word of the current LED and move to the next one.
      if (cmd.pixel_step) begin
         out_in             = '0;
         out_in.result_kind = sledc_pkg::RESULT_PIXEL;
         out_in.result_led  = 3'(ptr_ff);
         out_in.pixel_color = {lv[1], lv[0], lv[2]};
         out_in.last_pixel  = (ptr_ff == LAST_PTR);
         out_valid_in       = 1'b1;
         if (bright_ff != sledc_pkg::LEVEL_OFF && bright_ff != sledc_pkg::LEVEL_FULL) begin
            for (int c = 0; c < 3; c++) begin
               prev_in[ptr_ff][c] = lv[c];
            end
         end
         ptr_in = PTR_W'(ptr_ff + PTR_W'(1));
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         clock_ff     <= '0;
         last_ff      <= '0;
         usb_ff       <= 1'b0;
         bright_ff    <= sledc_pkg::BRIGHTNESS_RESET;
         len_ff       <= sledc_pkg::BLINK_LEN_RESET;
         period_ff    <= sledc_pkg::REFRESH_RESET;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEDS; i++) begin
            static_ff[i] <= '0;
            blink_ff[i]  <= '0;
            for (int c = 0; c < 3; c++) begin
               on_ff[i][c]   <= '0;
               off_ff[i][c]  <= '0;
               prev_ff[i][c] <= '0;
            end
         end
      end else begin
         ptr_ff       <= ptr_in;
         clock_ff     <= clock_in;
         last_ff      <= last_in;
         usb_ff       <= usb_in;
         bright_ff    <= bright_in;
         len_ff       <= len_in;
         period_ff    <= period_in;
         out_valid_ff <= out_valid_in;
         static_ff    <= static_in;
         blink_ff     <= blink_in;
         on_ff        <= on_in;
         off_ff       <= off_in;
         prev_ff      <= prev_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

endmodule
